@@ src/lka_pkg.sv @@
package lka_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 15;
    localparam int RECIP_W = 13;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int NUM_W   = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;

    // luma weights in hundredths
    localparam logic [SUM_W-1:0] W_RED   = 15'd30;
    localparam logic [SUM_W-1:0] W_GREEN = 15'd59;
    localparam logic [SUM_W-1:0] W_BLUE  = 15'd11;

    // floor(x/100) == (x*5243) >> 19 for every weighted sum below 25600
    localparam logic [RECIP_W-1:0] LUMA_RECIP = 13'd5243;
    localparam int LUMA_SHIFT = 19;

    localparam logic [PIX_W-1:0] SLOPE_MAX = 8'd128;

    localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd128;
    localparam logic [PIX_W-1:0] RST_SLOPE     = 8'd0;
    localparam logic [PIX_W-1:0] RST_PRELEVEL  = 8'd0;
    localparam logic [PIX_W-1:0] RST_POSTLEVEL = 8'd255;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_PRELEVEL  = 2'd2,
        CFG_POSTLEVEL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [PIX_W-1:0] slope;
        logic [PIX_W-1:0] prelevel;
        logic [PIX_W-1:0] postlevel;
    } cfg_t;

    typedef enum logic [1:0] {
        SEL_PRE  = 2'd0,
        SEL_POST = 2'd1,
        SEL_RAMP = 2'd2
    } sel_t;

    // state carried from cell to cell along the divider chain
    typedef struct packed {
        sel_t             sel;
        logic             neg;
        logic [PIX_W-1:0] pre;
        logic [PIX_W-1:0] post;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] num;
        logic [PIX_W-1:0] quot;
    } div_t;

endpackage

@@ src/lka_front.sv @@
module lka_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  lka_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_red,
    input  logic [7:0]          in_green,
    input  logic [7:0]          in_blue,
    output logic                out_valid,
    input  logic                out_ready,
    output lka_pkg::div_t       out_data
);
    import lka_pkg::*;

    logic               sum_valid_reg, luma_valid_reg, div_valid_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PIX_W-1:0]   luma_reg, luma_next;
    div_t               div_reg, div_next;
    logic               take_sum, take_luma, take_div;
    logic [PROD_W-1:0]  prod;

    logic [PIX_W-1:0]   slope_sat, ramp_start, ramp_end, diff, offs;
    logic [PIX_W:0]     end_sum;
    logic [NUM_W-1:0]   numer;
    logic               neg;

    assign take_div  = ~div_valid_reg | out_ready;
    assign take_luma = ~luma_valid_reg | take_div;
    assign take_sum  = ~sum_valid_reg | take_luma;
    assign in_ready  = take_sum;

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

    // weighted sum of the three components
    assign sum_next = {7'b0, in_red} * W_RED + {7'b0, in_green} * W_GREEN
                    + {7'b0, in_blue} * W_BLUE;

    // divide by 100 through the reciprocal
    assign prod      = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, LUMA_RECIP};
    assign luma_next = prod[LUMA_SHIFT +: PIX_W];

    // ramp bounds from the settings
    always_comb begin
        slope_sat  = (cfg.slope > SLOPE_MAX) ? SLOPE_MAX : cfg.slope;
        ramp_start = (cfg.threshold >= slope_sat) ? (cfg.threshold - slope_sat) : '0;
        end_sum    = {1'b0, cfg.threshold} + {1'b0, slope_sat};
        ramp_end   = end_sum[PIX_W] ? {PIX_W{1'b1}} : end_sum[PIX_W-1:0];
        neg        = cfg.postlevel < cfg.prelevel;
        diff       = neg ? (cfg.prelevel - cfg.postlevel) : (cfg.postlevel - cfg.prelevel);
        offs       = luma_reg - ramp_start;
        numer      = {{PIX_W{1'b0}}, offs} * {{PIX_W{1'b0}}, diff};
    end

    always_comb begin
        div_next.neg  = neg;
        div_next.pre  = cfg.prelevel;
        div_next.post = cfg.postlevel;
        div_next.quot = '0;
        if (luma_reg >= ramp_end) begin
            div_next.sel = SEL_POST;
        end else if (luma_reg < ramp_start) begin
            div_next.sel = SEL_PRE;
        end else begin
            div_next.sel = SEL_RAMP;
        end
        if (div_next.sel == SEL_RAMP) begin
            // high half is below the divisor, so the quotient fits 8 bits
            div_next.den = ramp_end - ramp_start;
            div_next.rem = numer[NUM_W-1:PIX_W];
            div_next.num = numer[PIX_W-1:0];
        end else begin
            div_next.den = {{(PIX_W-1){1'b0}}, 1'b1};
            div_next.rem = '0;
            div_next.num = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg  <= 1'b0;
            luma_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end else begin
            if (take_sum)  sum_valid_reg  <= in_valid;
            if (take_luma) luma_valid_reg <= sum_valid_reg;
            if (take_div)  div_valid_reg  <= luma_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sum)  sum_reg  <= sum_next;
        if (take_luma) luma_reg <= luma_next;
        if (take_div)  div_reg  <= div_next;
    end

endmodule

@@ src/lka_div_cell.sv @@
module lka_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lka_pkg::div_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lka_pkg::div_t  out_data
);
    import lka_pkg::*;

    logic             valid_reg;
    div_t             data_reg, data_next;
    logic [PIX_W:0]   shifted;
    logic             ge;

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one restoring division step: bring down a bit, subtract if it fits
    always_comb begin
        shifted   = {in_data.rem, in_data.num[PIX_W-1]};
        ge        = shifted >= {1'b0, in_data.den};
        data_next = in_data;
        if (ge) begin
            data_next.rem = shifted[PIX_W-1:0] - in_data.den;
        end else begin
            data_next.rem = shifted[PIX_W-1:0];
        end
        data_next.num  = {in_data.num[PIX_W-2:0], 1'b0};
        data_next.quot = {in_data.quot[PIX_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) data_reg <= data_next;
    end

endmodule

@@ src/lka_out.sv @@
module lka_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lka_pkg::div_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_alpha
);
    import lka_pkg::*;

    logic             valid_reg;
    logic [PIX_W-1:0] alpha_reg, alpha_next;
    logic             rem_nz;

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_alpha = alpha_reg;

    assign rem_nz = |in_data.rem;

    always_comb begin
        case (in_data.sel)
            SEL_PRE:  alpha_next = in_data.pre;
            SEL_POST: alpha_next = in_data.post;
            SEL_RAMP: begin
                // falling ramp rounds toward minus infinity
                if (in_data.neg) begin
                    alpha_next = in_data.pre - in_data.quot - {{(PIX_W-1){1'b0}}, rem_nz};
                end else begin
                    alpha_next = in_data.pre + in_data.quot;
                end
            end
            default:  alpha_next = in_data.pre;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) alpha_reg <= alpha_next;
    end

endmodule

@@ src/luma_key_alpha.sv @@
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------
// input     | s_valid / s_ready | s_red, s_green, s_blue (8 bits)
// result    | m_valid / m_ready | m_alpha (8 bits)
// config    | cfg_wr_en         | cfg_addr (2 bits), cfg_wdata (8 bits)
//
// one item per clock unless the result stalls; each item passes through
// three front stages (weighted sum, divide by 100, ramp setup), a chain of
// eight divider cells giving one quotient bit each, and the output register.
// aresetn is synchronous; it empties the pipeline and restores the settings.
// a stalled result holds only the stages behind it; bubbles close up.
module luma_key_alpha (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_alpha
);
    import lka_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic  chain_valid [DIV_STEPS+1];
    logic  chain_ready [DIV_STEPS+1];
    div_t  chain_data  [DIV_STEPS+1];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_THRESHOLD: cfg_next.threshold = cfg_wdata;
                CFG_SLOPE:     cfg_next.slope     = cfg_wdata;
                CFG_PRELEVEL:  cfg_next.prelevel  = cfg_wdata;
                CFG_POSTLEVEL: cfg_next.postlevel = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= RST_THRESHOLD;
            cfg_reg.slope     <= RST_SLOPE;
            cfg_reg.prelevel  <= RST_PRELEVEL;
            cfg_reg.postlevel <= RST_POSTLEVEL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lka_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_red),
        .in_green  (s_green),
        .in_blue   (s_blue),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        lka_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    lka_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[DIV_STEPS]),
        .in_ready  (chain_ready[DIV_STEPS]),
        .in_data   (chain_data[DIV_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_alpha (m_alpha)
    );

endmodule

@@ verif/luma_key_alpha_check.sv @@
module luma_key_alpha_check (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_alpha,
    output int         mismatches,
    output int         alpha_pending
);
    import lka_pkg::*;

    logic [PIX_W-1:0] thr_q;
    logic [PIX_W-1:0] slope_q;
    logic [PIX_W-1:0] pre_q;
    logic [PIX_W-1:0] post_q;
    logic [PIX_W-1:0] alpha_due[$];

    function automatic int clamp_byte(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 255) begin
            return 255;
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] key_alpha(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b);
        int luma;
        int half;
        int lo;
        int hi;
        int pre;
        int post;
        int num;
        int den;
        int quo;
        int a;
        luma = (30 * int'(r) + 59 * int'(g) + 11 * int'(b)) / 100;
        // slope register saturates when used
        half = (slope_q > SLOPE_MAX) ? int'(SLOPE_MAX) : int'(slope_q);
        lo   = clamp_byte(int'(thr_q) - half);
        hi   = clamp_byte(int'(thr_q) + half);
        pre  = int'(pre_q);
        post = int'(post_q);
        if (luma >= hi) begin
            a = post;
        end else if (luma < lo) begin
            a = pre;
        end else begin
            num = (luma - lo) * (post - pre);
            den = hi - lo;
            // falling ramp still rounds toward minus infinity
            if (num >= 0) begin
                quo = num / den;
            end else begin
                quo = -((-num + den - 1) / den);
            end
            a = pre + quo;
        end
        return PIX_W'(clamp_byte(a));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_q   = RST_THRESHOLD;
            slope_q = RST_SLOPE;
            pre_q   = RST_PRELEVEL;
            post_q  = RST_POSTLEVEL;
            alpha_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (alpha_due.size() == 0) begin
                    $error("alpha: unexpected item, actual %0d", m_alpha);
                    mismatches++;
                end else begin
                    logic [PIX_W-1:0] want;
                    want = alpha_due.pop_front();
                    if (m_alpha !== want) begin
                        $error("alpha: expected %0d, actual %0d", want, m_alpha);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                alpha_due.push_back(key_alpha(s_red, s_green, s_blue));
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_THRESHOLD: thr_q   = cfg_wdata;
                    CFG_SLOPE:     slope_q = cfg_wdata;
                    CFG_PRELEVEL:  pre_q   = cfg_wdata;
                    CFG_POSTLEVEL: post_q  = cfg_wdata;
                    default: ;
                endcase
            end
        end
        alpha_pending = alpha_due.size();
    end

endmodule

@@ verif/luma_key_alpha_tb.sv @@
module luma_key_alpha_tb;
    import lka_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_red;
    logic [7:0] s_green;
    logic [7:0] s_blue;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_alpha;

    int   mismatches;
    int   alpha_pending;
    int   idle_pct;
    int   stall_pct;
    logic hold_go;
    int   hold_left;

    // stimulus-side copy of the settings, used only to aim pixels at the band
    int   cur_thr;
    int   cur_slope;

    luma_key_alpha uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_alpha   (m_alpha)
    );

    luma_key_alpha_check checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_alpha       (m_alpha),
        .mismatches    (mismatches),
        .alpha_pending (alpha_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("luma_key_alpha: mismatch");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_go && hold_left == 0) begin
                hold_left = 80;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic rdy;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    task automatic send_gray(input logic [7:0] v);
        send_pixel(v, v, v);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (alpha_pending != 0) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic cfg_word(input cfg_idx_t idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_key(input int thr, input int slope, input int pre, input int post);
        cfg_word(CFG_THRESHOLD, 8'(thr));
        cfg_word(CFG_SLOPE, 8'(slope));
        cfg_word(CFG_PRELEVEL, 8'(pre));
        cfg_word(CFG_POSTLEVEL, 8'(post));
        cfg_wr_en <= 1'b0;
        cur_thr   = thr;
        cur_slope = slope;
    endtask

    task automatic send_random_pixel;
        int sel;
        int half;
        int lo;
        int hi;
        int v;
        sel = $urandom_range(99);
        if (sel < 50) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end else if (sel < 90) begin
            // gray pixel: luma equals the level, aimed around the ramp
            half = (cur_slope > 128) ? 128 : cur_slope;
            lo   = (cur_thr - half - 3 < 0) ? 0 : cur_thr - half - 3;
            hi   = (cur_thr + half + 3 > 255) ? 255 : cur_thr + half + 3;
            v    = $urandom_range(hi, lo);
            send_gray(8'(v));
        end else begin
            send_pixel({8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                       {8{1'($urandom_range(1))}});
        end
    endtask

    initial begin
        int thr;
        int slope;
        int pre;
        int post;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_THRESHOLD;
        cfg_wdata = 8'd0;
        s_valid   = 1'b0;
        s_red     = 8'd0;
        s_green   = 8'd0;
        s_blue    = 8'd0;
        hold_go   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        cur_thr   = RST_THRESHOLD;
        cur_slope = RST_SLOPE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero-width band, luma at threshold goes to postlevel
        send_gray(8'd0);
        send_gray(8'd255);
        send_gray(8'd128);
        send_gray(8'd127);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        drain();

        // saturated slope with a falling ramp
        set_key(100, 200, 200, 10);
        send_gray(8'd0);
        send_gray(8'd1);
        send_gray(8'd50);
        send_gray(8'd114);
        send_gray(8'd227);
        send_gray(8'd228);
        send_gray(8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        drain();

        // band end clamped at the top of the range
        set_key(255, 128, 0, 255);
        send_gray(8'd126);
        send_gray(8'd127);
        send_gray(8'd200);
        send_gray(8'd254);
        send_gray(8'd255);
        drain();

        set_key(64, 3, 17, 240);
        send_gray(8'd60);
        send_gray(8'd61);
        send_gray(8'd66);
        send_gray(8'd67);
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_key(0, 0, 0, 255);
                1: set_key(255, 255, 255, 0);
                2: set_key(128, 128, 0, 255);
                default: begin
                    thr   = $urandom_range(255);
                    slope = ($urandom_range(3) == 0) ? $urandom_range(255, 129)
                                                     : $urandom_range(128);
                    pre   = ($urandom_range(3) == 0) ? 255 * $urandom_range(1)
                                                     : $urandom_range(255);
                    post  = ($urandom_range(3) == 0) ? 255 * $urandom_range(1)
                                                     : $urandom_range(255);
                    set_key(thr, slope, pre, post);
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (p == 4) begin
                // long receiver hold-off while items keep coming
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end
            for (int i = 0; i < 130; i++) begin
                send_random_pixel();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("luma_key_alpha: match");
        end else begin
            $display("luma_key_alpha: mismatch");
        end
        $finish;
    end

endmodule
